@@ hdl/hex_real_ieee_double_converter_macros.svh @@
// assertion macros for the hex real converter
`ifndef HEX_REAL_IEEE_DOUBLE_CONVERTER_MACROS_SVH
`define HEX_REAL_IEEE_DOUBLE_CONVERTER_MACROS_SVH
`ifndef ASSERT_OFF
`define HRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HRC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define HRC_ASSERT(label, prop, msg)
`define HRC_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

@@ hdl/hrc_pkg.sv @@
package hrc_pkg;

    localparam int FRAC_W = 56;
    localparam int POS_W  = 6;
    localparam int EXP_W  = 12;

    localparam logic [63:0] HEX_MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic {
        REQ_HEX_TO_IEEE = 1'b0,
        REQ_IEEE_TO_HEX = 1'b1
    } req_t;

    typedef struct packed {
        logic              valid;
        req_t              req_type;
        logic              sign;
        logic              zero;
        logic [6:0]        e7;
        logic [FRAC_W-1:0] frac;
        logic [POS_W-1:0]  pos;
        logic [63:0]       hex_word;
        logic              flag;
    } s1_t;

    typedef struct packed {
        logic              valid;
        req_t              req_type;
        logic              sign;
        logic              zero;
        logic [EXP_W-1:0]  exp;
        logic [FRAC_W-1:0] norm;
        logic [63:0]       hex_word;
        logic              flag;
    } s2_t;

    // position of the highest set bit, 0 for zero
    function automatic logic [POS_W-1:0] top_bit(input logic [FRAC_W-1:0] f);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < FRAC_W; i++)
        begin
            if (f[i])
                p = POS_W'(i);
        end
        return p;
    endfunction

endpackage

@@ hdl/hrc_decode.sv @@
module hrc_decode (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic        req_type,
    input  logic [63:0] word_in,
    output hrc_pkg::s1_t s1
);
    import hrc_pkg::*;

    hrc_pkg::s1_t s1_reg, s1_next;
    logic [11:0] eb_p1;
    logic [9:0]  q4;
    logic [1:0]  r;
    logic [55:0] hfrac;

    always_comb
    begin
        eb_p1 = {1'b0, word_in[62:52]} + 12'd1;
        q4    = eb_p1[11:2];
        r     = eb_p1[1:0];
        hfrac = {3'b000, 1'b1, word_in[51:0]} << r;
        s1_next.valid    = in_valid;
        s1_next.req_type = req_t'(req_type);
        s1_next.sign     = word_in[63];
        s1_next.e7       = word_in[62:56];
        s1_next.frac     = word_in[55:0];
        s1_next.zero     = (word_in[55:0] == '0);
        s1_next.pos      = top_bit(word_in[55:0]);
        s1_next.flag     = 1'b0;
        // ieee to hex is done here in full
        if (word_in[62:52] == 11'h7FF)
        begin
            s1_next.flag     = 1'b1;
            s1_next.hex_word = {word_in[63], 63'(HEX_MAX_MAG)};
        end
        else if (word_in[62:52] == 11'h000)
        begin
            s1_next.flag     = (word_in[51:0] != '0);
            s1_next.hex_word = '0;
        end
        else if (q4 > 10'd318)
        begin
            s1_next.flag     = 1'b1;
            s1_next.hex_word = {word_in[63], 63'(HEX_MAX_MAG)};
        end
        else if (q4 < 10'd191)
        begin
            s1_next.flag     = 1'b1;
            s1_next.hex_word = '0;
        end
        else
        begin
            s1_next.hex_word = {word_in[63], 7'(q4 - 10'd191), hfrac};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg.valid <= 1'b0;
        else if (en)
            s1_reg <= s1_next;
    end

    assign s1 = s1_reg;

endmodule

@@ hdl/hrc_shift.sv @@
module hrc_shift (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  hrc_pkg::s1_t s1,
    output hrc_pkg::s2_t s2
);
    import hrc_pkg::*;

    s2_t s2_reg, s2_next;

    always_comb
    begin
        s2_next.valid    = s1.valid;
        s2_next.req_type = s1.req_type;
        s2_next.sign     = s1.sign;
        s2_next.zero     = s1.zero;
        // biased double exponent: p + 4*e7 + 711
        s2_next.exp      = EXP_W'(s1.pos) + {3'b000, s1.e7, 2'b00} + EXP_W'(711);
        s2_next.norm     = s1.frac << (POS_W'(FRAC_W - 1) - s1.pos);
        s2_next.hex_word = s1.hex_word;
        s2_next.flag     = s1.flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_reg.valid <= 1'b0;
        else if (en)
            s2_reg <= s2_next;
    end

    assign s2 = s2_reg;

endmodule

@@ hdl/hrc_round.sv @@
module hrc_round (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  hrc_pkg::s2_t s2,
    output logic         out_valid,
    output logic         out_req,
    output logic [63:0]  word_out,
    output logic         range_flag
);
    import hrc_pkg::*;

    logic        valid_reg;
    logic        req_reg, flag_reg, flag_next;
    logic [63:0] word_reg, word_next;
    logic [53:0] q_inc;
    logic        rnd;
    logic [EXP_W-1:0] exp_adj;

    always_comb
    begin
        // ties to even on the three bits below the kept 53
        rnd     = (s2.norm[2:0] > 3'd4) || (s2.norm[2:0] == 3'd4 && s2.norm[3]);
        q_inc   = {1'b0, s2.norm[55:3]} + 54'(rnd);
        exp_adj = s2.exp + EXP_W'(q_inc[53]);
        flag_next = 1'b0;
        if (s2.req_type == REQ_IEEE_TO_HEX)
        begin
            word_next = s2.hex_word;
            flag_next = s2.flag;
        end
        else if (s2.zero)
            word_next = {s2.sign, 63'd0};
        else
            word_next = {s2.sign, exp_adj[10:0], q_inc[53] ? 52'd0 : q_inc[51:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= s2.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
            flag_reg <= flag_next;
            req_reg  <= s2.req_type;
        end
    end

    assign out_valid  = valid_reg;
    assign out_req    = req_reg;
    assign word_out   = word_reg;
    assign range_flag = flag_reg;

endmodule

@@ hdl/hex_real_ieee_double_converter.sv @@
// throughput: one item per cycle; the whole pipe holds while a result is stalled
// stage 1 finds the leading one and does ieee to hex, stage 2 normalizes,
// stage 3 rounds to nearest even and holds the result
// reset: asynchronous, active low, clears the stage valid bits only
`include "hex_real_ieee_double_converter_macros.svh"
module hex_real_ieee_double_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [63:0] word_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] word_out,
    output logic        range_flag
);
    import hrc_pkg::*;

    s1_t  s1;
    s2_t  s2;
    logic en;
    logic out_req;
    logic range_word_ok;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // out of range gives zero or the largest magnitude
    assign range_word_ok = (word_out == 64'd0) || (word_out[62:0] == 63'(HEX_MAX_MAG));

    hrc_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .req_type (req_type),
        .word_in  (word_in),
        .s1       (s1)
    );

    hrc_shift u_shift (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .s1    (s1),
        .s2    (s2)
    );

    hrc_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .s2         (s2),
        .out_valid  (out_valid),
        .out_req    (out_req),
        .word_out   (word_out),
        .range_flag (range_flag)
    );

    `HRC_ASSERT(a_flag_dir, !(out_valid && range_flag) || out_req, "flag on hex to ieee")
    `HRC_ASSERT_NEXT(a_advance, s2.valid && en, out_valid, "stage 2 item lost")
    `HRC_ASSERT(a_flag_word, !(out_valid && range_flag) || range_word_ok, "bad range result")

endmodule

@@ tb/hex_real_ieee_double_converter_test.sv @@
`timescale 1ns / 1ps
module hex_real_ieee_double_converter_test;
    import hrc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [63:0] word_in;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] word_out;
    logic        range_flag;

    typedef struct packed {
        logic [63:0] word;
        logic        flag;
    } conv_result_t;

    conv_result_t pending_results[$];
    int           error_count;
    int           sent_count;
    int           checked_count;
    int           cycle_count;
    logic         stall_enable;

    localparam int CYCLE_LIMIT = 400000;

    hex_real_ieee_double_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .word_in    (word_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_out   (word_out),
        .range_flag (range_flag)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int msb_index(input logic [63:0] x);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
                p = i;
        end
        return p;
    endfunction

    function automatic logic [63:0] hex_to_double(input logic [63:0] w);
        logic        s;
        int          e7;
        logic [63:0] f;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int          p;
        int          unb;
        int          sh;
        s = w[63];
        e7 = int'(w[62:56]);
        f = {8'h00, w[55:0]};
        if (f == 64'd0)
            return {s, 63'd0};
        p = msb_index(f);
        unb = p + 4 * (e7 - 64) - 56;
        if (p > 52)
        begin
            sh = p - 52;
            rem = f & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            q = f >> sh;
            if (rem > half || (rem == half && q[0]))
                q = q + 64'd1;
            if (q[53])
            begin
                q = q >> 1;
                unb = unb + 1;
            end
        end
        else
            q = f << (52 - p);
        return {s, 11'(unb + 1023), q[51:0]};
    endfunction

    function automatic conv_result_t double_to_hex(input logic [63:0] w);
        conv_result_t r;
        int           eb;
        int           x;
        int           sh;
        logic [63:0]  m;
        eb = int'(w[62:52]);
        r.flag = 1'b0;
        if (eb == 2047)
        begin
            r.flag = 1'b1;
            r.word = {w[63], 63'h0} | HEX_MAX_MAG;
            return r;
        end
        if (eb == 0)
        begin
            r.flag = (w[51:0] != 52'd0);
            r.word = 64'd0;
            return r;
        end
        x = (eb + 1) / 4 - 256 + 1;
        sh = (eb + 1) & 3;
        if (x > 63)
        begin
            r.flag = 1'b1;
            r.word = {w[63], 63'h0} | HEX_MAX_MAG;
            return r;
        end
        if (x < -64)
        begin
            r.flag = 1'b1;
            r.word = 64'd0;
            return r;
        end
        m = ({12'h001, w[51:0]} << sh) & 64'h00FF_FFFF_FFFF_FFFF;
        r.word = {w[63], 7'(64 + x), m[55:0]};
        return r;
    endfunction

    function automatic conv_result_t convert_word(input logic rt, input logic [63:0] w);
        conv_result_t r;
        if (rt == REQ_HEX_TO_IEEE)
        begin
            r.word = hex_to_double(w);
            r.flag = 1'b0;
        end
        else
            r = double_to_hex(w);
        return r;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic add_expected(input conv_result_t r);
        pending_results = {pending_results, r};
    endtask

    // valid stays high into the next transfer when there is no gap
    task automatic send_word(input logic rt, input logic [63:0] w);
        int gap;
        gap = random_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        word_in  <= w;
        add_expected(convert_word(rt, w));
        sent_count++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!stall_enable)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 39) == 0)
            out_stall <= 1'b1;
        else if (out_stall && $urandom_range(0, 7) != 0)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        conv_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transfer word %h flag %b", $time, word_out,
                    range_flag);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                checked_count++;
                if (word_out !== exp_r.word)
                begin
                    $display("%0t: word_out expected %h actual %h", $time, exp_r.word,
                        word_out);
                    error_count++;
                end
                if (range_flag !== exp_r.flag)
                begin
                    $display("%0t: range_flag expected %b actual %b", $time, exp_r.flag,
                        range_flag);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_hex_edges();
        send_word(REQ_HEX_TO_IEEE, 64'h0000_0000_0000_0000);
        send_word(REQ_HEX_TO_IEEE, 64'hFF00_0000_0000_0000);
        send_word(REQ_HEX_TO_IEEE, 64'h4110_0000_0000_0000);
        send_word(REQ_HEX_TO_IEEE, 64'hC110_0000_0000_0000);
        send_word(REQ_HEX_TO_IEEE, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(REQ_HEX_TO_IEEE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(REQ_HEX_TO_IEEE, 64'h0000_0000_0000_0001);
        send_word(REQ_HEX_TO_IEEE, 64'h4000_0000_0000_0001);
        // rounding: even ties stay, odd ties go up; then a case below half and one that carries out
        send_word(REQ_HEX_TO_IEEE, 64'h4180_0000_0000_0004);
        send_word(REQ_HEX_TO_IEEE, 64'h4180_0000_0000_000C);
        send_word(REQ_HEX_TO_IEEE, 64'h4180_0000_0000_0009);
        send_word(REQ_HEX_TO_IEEE, 64'h40FF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_ieee_edges();
        send_word(REQ_IEEE_TO_HEX, 64'h0000_0000_0000_0000);
        send_word(REQ_IEEE_TO_HEX, 64'h8000_0000_0000_0000);
        send_word(REQ_IEEE_TO_HEX, 64'h0000_0000_0000_0001);
        send_word(REQ_IEEE_TO_HEX, 64'h7FF0_0000_0000_0000);
        send_word(REQ_IEEE_TO_HEX, 64'hFFF0_0000_0000_0000);
        send_word(REQ_IEEE_TO_HEX, 64'h7FF8_0000_0000_0001);
        send_word(REQ_IEEE_TO_HEX, 64'h3FF0_0000_0000_0000);
        send_word(REQ_IEEE_TO_HEX, 64'hBFFF_FFFF_FFFF_FFFF);
        send_word(REQ_IEEE_TO_HEX, 64'h7FEF_FFFF_FFFF_FFFF);
        send_word(REQ_IEEE_TO_HEX, 64'h0010_0000_0000_0000);
        // around the hex exponent limits
        send_word(REQ_IEEE_TO_HEX, 64'h4EF0_0000_0000_0000);
        send_word(REQ_IEEE_TO_HEX, 64'h4F00_0000_0000_0000);
        send_word(REQ_IEEE_TO_HEX, 64'h2F00_0000_0000_0000);
        send_word(REQ_IEEE_TO_HEX, 64'h2EF0_0000_0000_0000);
    endtask

    task automatic test_random_mix(input int count);
        logic [63:0] w;
        logic        rt;
        for (int i = 0; i < count; i++)
        begin
            rt = 1'($urandom_range(0, 1));
            w = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: w[55:0] = w[55:0] >> $urandom_range(0, 55);
                1: if (rt == REQ_IEEE_TO_HEX)
                        w[62:52] = 11'($urandom_range(700, 1300));
                2: if (rt == REQ_IEEE_TO_HEX)
                        w[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
                default: ;
            endcase
            send_word(rt, w);
            if (i == count / 2)
                wait_drained();
        end
        in_valid <= 1'b0;
    endtask

    task automatic test_back_to_back(input int count);
        stall_enable = 1'b0;
        @(negedge clk);
        in_valid <= 1'b1;
        for (int i = 0; i < count; i++)
        begin
            req_type <= i[0];
            word_in  <= {$urandom, $urandom};
            @(posedge clk);
            add_expected(convert_word(req_type, word_in));
            sent_count++;
            while (in_stall)
                @(posedge clk);
            @(negedge clk);
        end
        in_valid <= 1'b0;
        stall_enable = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        word_in = 64'd0;
        stall_enable = 1'b0;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        cycle_count = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        stall_enable = 1'b1;
        test_hex_edges();
        test_ieee_edges();
        wait_drained();
        test_random_mix(1600);
        test_back_to_back(220);
        wait_drained();
        $display("converted %0d words both ways, %0d results checked", sent_count,
            checked_count);
        $display("covered zeros, rounding ties, range limits, inf/nan and stalls");
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
